/* hdl/tse_pkg.sv */
// Shared constants, state encoding and controller/datapath interface types.
package tse_pkg;

  localparam int X_W      = 20;
  localparam int VAL_W    = 44;
  localparam int N_W      = 7;
  localparam int TOL_W    = 32;
  localparam int PROD_W   = 64;
  localparam int NUM_W    = 65;
  localparam int QUO_W    = 48;
  localparam int FRAC_X   = 16;
  localparam int PAD_W    = NUM_W - QUO_W;
  localparam int STEP_W   = 7;
  localparam int S_DATA_W = 24;
  localparam int M_DATA_W = 56;
  localparam int M_USER_W = 2;

  localparam logic [N_W-1:0]    MAX_TERMS   = 7'd64;
  localparam logic [VAL_W-1:0]  ONE_Q32     = 44'h001_0000_0000;
  localparam logic [VAL_W-1:0]  MAX_Q44     = 44'hFFF_FFFF_FFFF;
  localparam logic [TOL_W-1:0]  TOL_RESET   = 32'd43;
  localparam logic [STEP_W-1:0] STEPS_TERM  = 7'd48;
  localparam logic [STEP_W-1:0] STEPS_RECIP = 7'd65;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_DIV_GO,
    ST_DIV_WAIT,
    ST_RECIP_GO,
    ST_RECIP_WAIT,
    ST_OUTPUT
  } state_t;

  typedef struct packed {
    logic load;
    logic mul;
    logic div_start;
    logic div_recip;
    logic accum;
    logic step_n;
  } cmd_t;

  typedef struct packed {
    logic div_busy;
    logic term_small;
    logic at_limit;
    logic neg;
  } status_t;

  typedef struct packed {
    logic             saturated;
    logic             not_converged;
    logic [N_W-1:0]   terms_used;
    logic [VAL_W-1:0] exp_result;
  } result_t;

endpackage

/* hdl/tse_div.sv */
// Restoring long divider, one quotient bit per cycle, left-aligned numerator.
module tse_div (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [tse_pkg::NUM_W-1:0]   numer,
  input  logic [tse_pkg::VAL_W-1:0]   denom,
  input  logic [tse_pkg::STEP_W-1:0]  steps,
  output logic                        busy,
  output logic [tse_pkg::QUO_W-1:0]   quot
);
  import tse_pkg::*;

  logic [NUM_W-1:0]  num;
  logic [VAL_W-1:0]  rem;
  logic [VAL_W-1:0]  dvs;
  logic [STEP_W-1:0] cnt;
  logic [VAL_W:0]    rem_sh;
  logic [VAL_W:0]    diff;
  logic              ge;

  assign rem_sh = {rem, num[NUM_W-1]};
  assign ge     = rem_sh >= {1'b0, dvs};
  assign diff   = rem_sh - {1'b0, dvs};
  assign busy   = cnt != '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (start) begin
      cnt <= steps;
    end else if (busy) begin
      cnt <= cnt - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      num  <= numer;
      dvs  <= denom;
      rem  <= '0;
      quot <= '0;
    end else if (busy) begin
      num  <= {num[NUM_W-2:0], 1'b0};
      rem  <= ge ? diff[VAL_W-1:0] : rem_sh[VAL_W-1:0];
      quot <= {quot[QUO_W-2:0], ge};
    end
  end

endmodule

/* hdl/tse_datapath.sv */
// Series datapath: term, sum, multiplier, shared divider and tolerance register.
module tse_datapath (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_we,
  input  logic [tse_pkg::TOL_W-1:0]  cfg_data,
  input  logic [tse_pkg::X_W-1:0]    x_value,
  input  tse_pkg::cmd_t              cmd,
  output tse_pkg::status_t           status,
  output tse_pkg::result_t           result
);
  import tse_pkg::*;

  logic [TOL_W-1:0]  tol;
  logic [X_W-1:0]    mag;
  logic              neg;
  logic [VAL_W-1:0]  term;
  logic [VAL_W-1:0]  sum;
  logic [N_W-1:0]    n;
  logic              sat;
  logic              conv;
  logic [PROD_W-1:0] prod;

  logic [NUM_W-1:0]  numer;
  logic [VAL_W-1:0]  denom;
  logic [STEP_W-1:0] steps;
  logic              div_busy;
  logic [QUO_W-1:0]  quot;
  logic [VAL_W-1:0]  new_term;
  logic [VAL_W:0]    add;

  assign numer = cmd.div_recip ? {1'b1, {(NUM_W-1){1'b0}}}
                               : {prod[PROD_W-1:FRAC_X], {PAD_W{1'b0}}};
  assign denom = cmd.div_recip ? sum : {{(VAL_W-N_W){1'b0}}, n};
  assign steps = cmd.div_recip ? STEPS_RECIP : STEPS_TERM;

  tse_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (cmd.div_start),
    .numer (numer),
    .denom (denom),
    .steps (steps),
    .busy  (div_busy),
    .quot  (quot)
  );

  assign new_term = quot[VAL_W-1:0];
  assign add      = {1'b0, sum} + {1'b0, new_term};

  always_ff @(posedge clk) begin
    if (rst) begin
      tol <= TOL_RESET;
    end else if (cfg_we) begin
      tol <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      mag  <= x_value[X_W-1] ? X_W'(~x_value + 1'b1) : x_value;
      neg  <= x_value[X_W-1];
      term <= ONE_Q32;
      sum  <= ONE_Q32;
      n    <= N_W'(1);
      sat  <= 1'b0;
      conv <= 1'b0;
    end else begin
      if (cmd.mul) begin
        prod <= PROD_W'(term * mag);
      end
      if (cmd.accum) begin
        term <= new_term;
        sum  <= add[VAL_W] ? MAX_Q44 : add[VAL_W-1:0];
        sat  <= sat | add[VAL_W];
        conv <= status.term_small;
      end
      if (cmd.step_n) begin
        n <= n + 1'b1;
      end
    end
  end

  assign status.div_busy   = div_busy;
  assign status.term_small = new_term < {{(VAL_W-TOL_W){1'b0}}, tol};
  assign status.at_limit   = n == MAX_TERMS;
  assign status.neg        = neg;

  // reciprocal is at most 2^32, so it never reaches the clamp
  assign result.exp_result    = neg ? quot[VAL_W-1:0] : sum;
  assign result.terms_used    = n;
  assign result.not_converged = ~conv;
  assign result.saturated     = sat;

endmodule

/* hdl/tse_ctrl.sv */
// Sequencing state machine: term loop, reciprocal and result hand-off.
module tse_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic              out_free,
  output logic              emit,
  input  tse_pkg::status_t  status,
  output tse_pkg::cmd_t     cmd
);
  import tse_pkg::*;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    emit       = 1'b0;
    case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = ST_MUL;
        end
      end
      ST_MUL: begin
        cmd.mul    = 1'b1;
        state_next = ST_DIV_GO;
      end
      ST_DIV_GO: begin
        cmd.div_start = 1'b1;
        state_next    = ST_DIV_WAIT;
      end
      ST_DIV_WAIT: begin
        if (!status.div_busy) begin
          cmd.accum = 1'b1;
          if (status.term_small || status.at_limit) begin
            state_next = status.neg ? ST_RECIP_GO : ST_OUTPUT;
          end else begin
            cmd.step_n = 1'b1;
            state_next = ST_MUL;
          end
        end
      end
      ST_RECIP_GO: begin
        cmd.div_start = 1'b1;
        cmd.div_recip = 1'b1;
        state_next    = ST_RECIP_WAIT;
      end
      ST_RECIP_WAIT: begin
        cmd.div_recip = 1'b1;
        if (!status.div_busy) begin
          state_next = ST_OUTPUT;
        end
      end
      ST_OUTPUT: begin
        if (out_free) begin
          emit       = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

/* hdl/taylor_series_exp_unit.sv */
// Top level of the Taylor-series exponential unit.
//
// Input words arrive on s_tvalid/s_tready/s_tdata, one argument x each
// (signed Q4.16). Results leave on m_tvalid/m_tready/m_tdata/m_tuser:
// exp(x) in unsigned Q12.32, the number of terms summed and two flags.
// The tolerance register is written through cfg_valid/cfg_ready/cfg_data,
// which is always ready; write it only while the unit is idle.
// One argument is worked on at a time. Each term takes one multiply,
// one divider start, a pass through the shared bit-serial divider and
// one accumulate. A negative argument adds a reciprocal through the
// same divider. The next word can be taken as soon as the result is
// loaded. The result sits in an output register, so a stalled receiver
// does not stop the next argument being taken; only the hand-off of
// that next result waits. Synchronous reset returns the unit to idle,
// drops m_tvalid and loads the tolerance with its default.
module taylor_series_exp_unit (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  input  logic [tse_pkg::S_DATA_W-1:0]  s_tdata,   // [19:0] x_value
  output logic                          m_tvalid,
  input  logic                          m_tready,
  output logic [tse_pkg::M_DATA_W-1:0]  m_tdata,   // [43:0] exp_result, [50:44] terms_used
  output logic [tse_pkg::M_USER_W-1:0]  m_tuser,   // [0] not_converged, [1] saturated
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [tse_pkg::TOL_W-1:0]     cfg_data
);
  import tse_pkg::*;

  cmd_t    cmd;
  status_t status;
  result_t result;
  logic    out_free;
  logic    emit;

  assign cfg_ready = 1'b1;
  assign out_free  = !m_tvalid || m_tready;

  tse_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .out_free (out_free),
    .emit     (emit),
    .status   (status),
    .cmd      (cmd)
  );

  tse_datapath u_dp (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_valid),
    .cfg_data (cfg_data),
    .x_value  (s_tdata[X_W-1:0]),
    .cmd      (cmd),
    .status   (status),
    .result   (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (emit) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      m_tdata <= {{(M_DATA_W-VAL_W-N_W){1'b0}}, result.terms_used, result.exp_result};
      m_tuser <= {result.saturated, result.not_converged};
    end
  end

endmodule

/* hdl/tse_checker.sv */
// Port-level checks for the exponential unit, bound to the top level.
module tse_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          s_tvalid,
  input logic                          s_tready,
  input logic                          m_tvalid,
  input logic                          m_tready,
  input logic [tse_pkg::M_DATA_W-1:0]  m_tdata,
  input logic [tse_pkg::M_USER_W-1:0]  m_tuser
);
  import tse_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("output word changed while stalled");

  a_reset_idle: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("output valid after reset");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("second word taken while one is in progress");

  a_terms_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[50:44] != '0 && m_tdata[50:44] <= MAX_TERMS)
    else $error("term count out of range");

  a_nonconv_limit: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser[0] |-> m_tdata[50:44] == MAX_TERMS)
    else $error("non-convergence flagged below the term limit");

endmodule

bind taylor_series_exp_unit tse_checker u_tse_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser)
);

/* verif/taylor_series_exp_unit_tb.sv */
`timescale 1ns / 100ps
// Self-checking testbench for the Taylor-series exponential unit.

class exp_scoreboard;
  logic [tse_pkg::TOL_W-1:0] tolerance;
  tse_pkg::result_t awaited[$];
  int errors;

  function new();
    tolerance = tse_pkg::TOL_RESET;
    errors = 0;
  endfunction

  function void report(string msg);
    $display("mismatch: %s", msg);
    errors++;
  endfunction

  // term_n = floor(floor(term_{n-1} * |x| / 2^16) / n); reciprocal for x < 0
  function tse_pkg::result_t predict_exp(logic [tse_pkg::X_W-1:0] x);
    tse_pkg::result_t r;
    logic [tse_pkg::X_W-1:0] negated;
    logic [63:0] mag;
    logic [63:0] term;
    logic [63:0] sum;
    logic [64:0] recip;
    logic below;
    logic sat;
    int n;
    int used;
    negated = -x;
    mag = x[tse_pkg::X_W-1] ? 64'(negated) : 64'(x);
    term = 64'(tse_pkg::ONE_Q32);
    sum = term;
    below = 1'b0;
    sat = 1'b0;
    used = 0;
    for (n = 1; n <= int'(tse_pkg::MAX_TERMS) && !below; n++) begin
      term = ((term * mag) >> tse_pkg::FRAC_X) / 64'(n);
      term = term & 64'(tse_pkg::MAX_Q44);
      sum = sum + term;
      if (sum > 64'(tse_pkg::MAX_Q44)) begin
        sum = 64'(tse_pkg::MAX_Q44);
        sat = 1'b1;
      end
      used = n;
      below = term < 64'(tolerance);
    end
    if (x[tse_pkg::X_W-1]) begin
      recip = {1'b1, 64'd0} / {1'b0, sum};
      if (recip > 65'(tse_pkg::MAX_Q44)) recip = 65'(tse_pkg::MAX_Q44);
      r.exp_result = recip[tse_pkg::VAL_W-1:0];
    end else begin
      r.exp_result = sum[tse_pkg::VAL_W-1:0];
    end
    r.terms_used = tse_pkg::N_W'(used);
    r.not_converged = !below;
    r.saturated = sat;
    return r;
  endfunction

  function void note_input(logic [tse_pkg::X_W-1:0] x);
    awaited.push_back(predict_exp(x));
  endfunction

  function void check_result(tse_pkg::result_t got);
    tse_pkg::result_t want;
    if (awaited.size() == 0) begin
      report($sformatf("result word with none awaited, exp_result %h", got.exp_result));
      return;
    end
    want = awaited.pop_front();
    if (got.exp_result !== want.exp_result)
      report($sformatf("exp_result %h, want %h", got.exp_result, want.exp_result));
    if (got.terms_used !== want.terms_used)
      report($sformatf("terms_used %0d, want %0d", got.terms_used, want.terms_used));
    if (got.not_converged !== want.not_converged)
      report($sformatf("not_converged %b, want %b", got.not_converged, want.not_converged));
    if (got.saturated !== want.saturated)
      report($sformatf("saturated %b, want %b", got.saturated, want.saturated));
  endfunction
endclass

module taylor_series_exp_unit_tb;
  import tse_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 5_000_000;
  localparam int DRAIN_CYCLES = 3_600;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [S_DATA_W-1:0] s_tdata = '0;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [M_DATA_W-1:0] m_tdata;
  logic [M_USER_W-1:0] m_tuser;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [TOL_W-1:0] cfg_data = '0;

  int unsigned cycles = 0;
  int unsigned stall_left = 0;
  int burst_left = 0;

  exp_scoreboard sb = new();

  taylor_series_exp_unit uut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  always #2 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  // receiver: windows of free flow, random stalls and long holds
  always @(posedge clk) begin
    if (stall_left != 0) begin
      m_tready <= 1'b0;
      stall_left <= stall_left - 1;
    end else begin
      case (cycles[14:13])
        2'd0: m_tready <= 1'b1;
        2'd1: m_tready <= $urandom_range(0, 1);
        2'd2: begin
          if ($urandom_range(0, 99) < 3) begin
            m_tready <= 1'b0;
            stall_left <= $urandom_range(1, 400);
          end else begin
            m_tready <= 1'b1;
          end
        end
        default: m_tready <= (cycles[3:0] < 4'd5);
      endcase
    end
  end

  always @(posedge clk) begin
    if (!rst && s_tvalid && s_tready) sb.note_input(s_tdata[X_W-1:0]);
    if (!rst && m_tvalid && m_tready)
      sb.check_result({m_tuser[1], m_tuser[0], m_tdata[VAL_W+N_W-1:VAL_W],
                       m_tdata[VAL_W-1:0]});
  end

  task automatic send_x(logic [X_W-1:0] x);
    s_tvalid <= 1'b1;
    s_tdata <= S_DATA_W'(x);
    do @(posedge clk); while (!s_tready);
  endtask

  task automatic send_paced(logic [X_W-1:0] x);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 600);
      if (gap != 0) begin
        s_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    send_x(x);
  endtask

  task automatic wait_drained();
    s_tvalid <= 1'b0;
    while (sb.awaited.size() != 0) @(posedge clk);
  endtask

  task automatic write_tolerance(logic [TOL_W-1:0] value);
    wait_drained();
    repeat (4) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    sb.tolerance = value;
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [X_W-1:0] random_x();
    logic [X_W-1:0] r;
    case ($urandom_range(0, 9))
      6, 7: r = X_W'($urandom_range(0, 20'h0FFFF));
      8: r = X_W'($urandom_range(20'h70000, 20'h7FFFF));
      9: begin
        case ($urandom_range(0, 3))
          0: r = '0;
          1: r = 20'h7FFFF;
          2: r = 20'h80000;
          default: r = 20'h00001;
        endcase
      end
      default: r = X_W'($urandom);
    endcase
    if ($urandom_range(6, 8) <= 8 && $urandom_range(0, 1) == 1 && r[X_W-1] == 1'b0)
      r = -r;
    return r;
  endfunction

  initial begin
    logic [X_W-1:0] corners [14];
    logic [TOL_W-1:0] tol;
    corners = '{20'h00000, 20'h00001, 20'hFFFFF, 20'h10000,
                20'hF0000, 20'h7FFFF, 20'h80000, 20'h80001,
                20'h40000, 20'hC0000, 20'h00100, 20'hFFF00,
                20'h55555, 20'hAAAAA};
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (corners[i]) send_paced(corners[i]);

    // zero tolerance: every argument runs to the term limit
    write_tolerance('0);
    send_x(20'h00000);
    send_x(20'h7FFFF);
    send_x(20'h80000);
    send_x(20'hFFFFF);
    repeat (10) send_paced(random_x());

    // full-scale tolerance: stops as soon as a term drops under 1.0
    write_tolerance('1);
    send_x(20'h00000);
    send_x(20'h7FFFF);
    send_x(20'h80000);
    send_x(20'h00001);
    repeat (20) send_paced(random_x());

    for (int p = 0; p < 5; p++) begin
      case (p)
        0: tol = 32'd1;
        1: tol = TOL_W'($urandom_range(1, 16));
        2: tol = TOL_W'($urandom);
        3: tol = TOL_W'($urandom_range(1, 1 << 20));
        default: tol = TOL_RESET;
      endcase
      write_tolerance(tol);
      repeat (50) send_paced(random_x());
    end

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.errors == 0 && sb.awaited.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end
endmodule
